// ===== src/bpa_pkg.sv =====
package bpa_pkg;

    localparam int STORE_WORDS_DEF = 4096;

    // Field widths of one item.
    localparam int IDX_W   = 18;
    localparam int WIDTH_W = 7;
    localparam int DATA_W  = 64;
    localparam int SLOT_W  = IDX_W + 1;
    localparam int BITPOS_W = SLOT_W + WIDTH_W;
    localparam int WORD_W  = BITPOS_W - 6;

    // Register indexes on the configuration port.
    localparam logic REG_ELEMENT_WIDTH   = 1'b0;
    localparam logic REG_RESERVED_OFFSET = 1'b1;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 7'd32;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef struct packed {
        logic                func;
        logic                oor;
        logic                spans;
        logic [WORD_W-1:0]   word;
        logic [5:0]          shift;
        logic [WIDTH_W-1:0]  width;
        logic [DATA_W-1:0]   value;
    } bpa_entry_t;

    // Mask of the low w bits, w in 1..64.
    function automatic logic [DATA_W-1:0] width_mask(input logic [WIDTH_W-1:0] w);
        logic [WIDTH_W-1:0] gap;
        gap = 7'd64 - w;
        return {DATA_W{1'b1}} >> gap[5:0];
    endfunction

endpackage

// ===== src/bpa_front.sv =====
module bpa_front
    import bpa_pkg::*;
#(
    parameter int STORE_WORDS = STORE_WORDS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                func,
    input  logic [IDX_W-1:0]    elem_index,
    input  logic [DATA_W-1:0]   write_value,
    input  logic [WIDTH_W-1:0]  element_width,
    input  logic [IDX_W-1:0]    reserved_offset,
    input  logic                clearing,
    input  logic                q_full,
    output logic                q_push,
    output bpa_entry_t          q_entry
);

    localparam logic [BITPOS_W:0] TOTAL_BITS = (BITPOS_W+1)'(STORE_WORDS * 64);

    logic                s1_v_reg, s1_v_next;
    logic                s1_func_reg;
    logic [SLOT_W-1:0]   s1_slot_reg;
    logic [WIDTH_W-1:0]  s1_width_reg;
    logic [DATA_W-1:0]   s1_value_reg;

    logic                s2_v_reg, s2_v_next;
    logic                s2_func_reg;
    logic [BITPOS_W-1:0] s2_bitpos_reg;
    logic [WIDTH_W-1:0]  s2_width_reg;
    logic [DATA_W-1:0]   s2_value_reg;

    logic                accept, s2_free, mv12, s1_free;
    logic [WIDTH_W-1:0]  eff_width;
    logic [BITPOS_W:0]   end_bit;
    logic [WIDTH_W-1:0]  shift_end;

    always_comb
    begin
        if (element_width == '0)
            eff_width = 7'd1;
        else if (element_width > 7'd64)
            eff_width = 7'd64;
        else
            eff_width = element_width;
    end

    assign q_push  = s2_v_reg && !q_full;
    assign s2_free = !s2_v_reg || q_push;
    assign mv12    = s1_v_reg && s2_free;
    assign s1_free = !s1_v_reg || mv12;
    assign busy    = clearing || !s1_free;
    assign accept  = start && !busy;

    assign s1_v_next = accept || (s1_v_reg && !mv12);
    assign s2_v_next = mv12 || (s2_v_reg && !q_push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= s1_v_next;
            s2_v_reg <= s2_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg  <= func;
            s1_slot_reg  <= SLOT_W'(elem_index) + SLOT_W'(reserved_offset);
            s1_width_reg <= eff_width;
            s1_value_reg <= write_value & width_mask(eff_width);
        end
        if (mv12)
        begin
            s2_func_reg   <= s1_func_reg;
            s2_bitpos_reg <= BITPOS_W'(s1_slot_reg) * BITPOS_W'(s1_width_reg);
            s2_width_reg  <= s1_width_reg;
            s2_value_reg  <= s1_value_reg;
        end
    end

    assign end_bit   = (BITPOS_W+1)'(s2_bitpos_reg) + (BITPOS_W+1)'(s2_width_reg);
    assign shift_end = WIDTH_W'(s2_bitpos_reg[5:0]) + s2_width_reg;

    always_comb
    begin
        q_entry.func  = s2_func_reg;
        q_entry.oor   = end_bit > TOTAL_BITS;
        q_entry.spans = shift_end > 7'd64;
        q_entry.word  = s2_bitpos_reg[BITPOS_W-1:6];
        q_entry.shift = s2_bitpos_reg[5:0];
        q_entry.width = s2_width_reg;
        q_entry.value = s2_value_reg;
    end

endmodule

// ===== src/bpa_queue.sv =====
module bpa_queue
    import bpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  bpa_entry_t  push_entry,
    output logic        full,
    input  logic        pop,
    output logic        empty,
    output bpa_entry_t  head
);

    bpa_entry_t  slots_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign head  = slots_reg[rd_ptr_reg];

    assign wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// ===== src/bpa_back.sv =====
module bpa_back
    import bpa_pkg::*;
#(
    parameter int STORE_WORDS = STORE_WORDS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  bpa_entry_t         q_head,
    output logic               q_pop,
    output logic               clearing,
    output logic               done,
    output logic [DATA_W-1:0]  read_data,
    output logic               out_of_range
);

    localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_WORDS - 1);

    localparam logic [2:0] B_CLR   = 3'd0;
    localparam logic [2:0] B_IDLE  = 3'd1;
    localparam logic [2:0] B_LO    = 3'd2;
    localparam logic [2:0] B_HI_RD = 3'd3;
    localparam logic [2:0] B_HI    = 3'd4;

    logic [DATA_W-1:0] mem [STORE_WORDS];

    logic [2:0]         state_reg, state_next;
    logic [AW-1:0]      clr_reg, clr_next;
    bpa_entry_t         cur_reg, cur_next;
    logic [DATA_W-1:0]  lo_reg, lo_next;
    logic [DATA_W-1:0]  rdata_reg;

    logic               done_reg, done_next;
    logic [DATA_W-1:0]  read_data_reg, read_data_next;
    logic               oor_reg, oor_next;

    logic               mem_we;
    logic [AW-1:0]      mem_addr;
    logic [DATA_W-1:0]  mem_wdata;

    logic [DATA_W-1:0]  mask;
    logic [DATA_W-1:0]  lo_part;
    logic [5:0]         up;
    logic [AW-1:0]      cur_word, next_word;

    assign mask      = width_mask(cur_reg.width);
    assign lo_part   = (rdata_reg >> cur_reg.shift) & mask;
    // Spanning implies a nonzero shift, so 64 - shift fits six bits.
    assign up        = 6'(7'd64 - {1'b0, cur_reg.shift});
    assign cur_word  = cur_reg.word[AW-1:0];
    assign next_word = cur_word + AW'(1);

    assign clearing     = state_reg == B_CLR;
    assign done         = done_reg;
    assign read_data    = read_data_reg;
    assign out_of_range = oor_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cur_next       = cur_reg;
        lo_next        = lo_reg;
        done_next      = 1'b0;
        read_data_next = '0;
        oor_next       = 1'b0;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_addr       = cur_word;
        mem_wdata      = '0;

        case (state_reg)
            B_CLR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_ADDR)
                    state_next = B_IDLE;
            end
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_head;
                    if (q_head.oor)
                    begin
                        done_next = 1'b1;
                        oor_next  = 1'b1;
                    end
                    else
                    begin
                        mem_addr   = q_head.word[AW-1:0];
                        state_next = B_LO;
                    end
                end
            end
            B_LO:
            begin
                if (cur_reg.func == FUNC_WRITE)
                begin
                    mem_we    = 1'b1;
                    mem_addr  = cur_word;
                    mem_wdata = (rdata_reg & ~(mask << cur_reg.shift))
                              | (cur_reg.value << cur_reg.shift);
                    if (cur_reg.spans)
                        state_next = B_HI_RD;
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = B_IDLE;
                    end
                end
                else if (cur_reg.spans)
                begin
                    lo_next    = lo_part;
                    mem_addr   = next_word;
                    state_next = B_HI;
                end
                else
                begin
                    done_next      = 1'b1;
                    read_data_next = lo_part;
                    state_next     = B_IDLE;
                end
            end
            B_HI_RD:
            begin
                mem_addr   = next_word;
                state_next = B_HI;
            end
            B_HI:
            begin
                done_next  = 1'b1;
                state_next = B_IDLE;
                if (cur_reg.func == FUNC_WRITE)
                begin
                    mem_we    = 1'b1;
                    mem_addr  = next_word;
                    mem_wdata = (rdata_reg & ~(mask >> up)) | (cur_reg.value >> up);
                end
                else
                    read_data_next = lo_reg | ((rdata_reg & (mask >> up)) << up);
            end
            default:
            begin
                state_next = B_CLR;
                clr_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        lo_reg        <= lo_next;
        read_data_reg <= read_data_next;
        oor_reg       <= oor_next;
    end

    // Single-port store, read-first.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rdata_reg <= mem[mem_addr];
    end

endmodule

// ===== src/bit_packed_array_access_unit.sv =====
// Channel   Handshake                     Payload
// input     start, busy (taken when low)  func, elem_index, write_value
// result    done (one-cycle strobe)       read_data, out_of_range
// config    APB write, pready always 1    element_width @0, reserved_offset @4
//
// Reset sweeps the store to zero, one word a cycle, with busy high throughout.
// An item passes two front stages; in the back B_IDLE pops it and reads its word, then B_LO
// serves a one-word access, B_LO and B_HI a two-word read, B_LO, B_HI_RD and B_HI a two-word
// write; none for an item past the store end (single-port store). The done strobe is registered.
// A two-entry queue lets the front take new items while the back works; results cannot stall.
module bit_packed_array_access_unit
    import bpa_pkg::*;
#(
    parameter int STORE_WORDS = STORE_WORDS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                func,
    input  logic [IDX_W-1:0]    elem_index,
    input  logic [DATA_W-1:0]   write_value,
    output logic                done,
    output logic [DATA_W-1:0]   read_data,
    output logic                out_of_range,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [WIDTH_W-1:0] element_width_reg;
    logic [IDX_W-1:0]   reserved_offset_reg;
    logic               cfg_write;
    logic               clearing;
    logic               q_full, q_push, q_pop, q_empty;
    bpa_entry_t         q_entry, q_head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_width_reg   <= WIDTH_RESET;
            reserved_offset_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_ELEMENT_WIDTH)
                element_width_reg <= pwdata[WIDTH_W-1:0];
            else
                reserved_offset_reg <= pwdata[IDX_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_ELEMENT_WIDTH)
            prdata = 32'(element_width_reg);
        else
            prdata = 32'(reserved_offset_reg);
    end

    bpa_front #(
        .STORE_WORDS(STORE_WORDS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .func            (func),
        .elem_index      (elem_index),
        .write_value     (write_value),
        .element_width   (element_width_reg),
        .reserved_offset (reserved_offset_reg),
        .clearing        (clearing),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_entry         (q_entry)
    );

    bpa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head       (q_head)
    );

    bpa_back #(
        .STORE_WORDS(STORE_WORDS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .clearing     (clearing),
        .done         (done),
        .read_data    (read_data),
        .out_of_range (out_of_range)
    );

endmodule
